// File: rtl/dfe_pkg.sv
// Shared constants for the delimited frame extractor.
package dfe_pkg;

    localparam int BYTE_W          = 8;
    localparam int POS_W           = 6;
    localparam int SIZE_W          = 7;
    localparam int MAX_FRAME_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] C_START = 8'h23;
    localparam logic [BYTE_W-1:0] C_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] C_LF    = 8'h0A;

endpackage

// File: rtl/dfe_front.sv
// Front end: accepts received bytes, tracks framing state and issues store commands.
module dfe_front
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    localparam int AW = $clog2(MAX_FRAME),
    localparam int CW = $clog2(MAX_FRAME + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output logic [BYTE_W-1:0] o_byte,
    output logic [AW-1:0]     o_addr,
    output logic              o_last
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_WAIT_LF = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic          w_accept;
    logic          w_full;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_full   = (r_count == CW'(MAX_FRAME));
    assign o_byte   = i_byte;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        o_push  = 1'b0;
        o_last  = 1'b0;
        o_addr  = r_count[AW-1:0];
        unique case (r_phase)
            PH_BODY: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else begin
                        o_push  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_byte == C_CR) begin
                            n_phase = PH_WAIT_LF;
                        end
                    end
                end
            end
            PH_WAIT_LF: begin
                if (w_accept) begin
                    if ((i_byte == C_LF) && !w_full) begin
                        o_push = 1'b1;
                        o_last = 1'b1;
                    end
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            end
            default: begin
                if (w_accept) begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                    o_addr  = '0;
                    if (i_byte == C_START) begin
                        o_push  = 1'b1;
                        n_count = CW'(1);
                        n_phase = PH_BODY;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/dfe_queue.sv
// Small command queue between the front end and the frame buffer.
module dfe_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dfe_back.sv
// Back end: writes frame bytes into the buffer and drains completed frames.
module dfe_back
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    localparam int AW = $clog2(MAX_FRAME),
    localparam int CW = $clog2(MAX_FRAME + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  logic [BYTE_W-1:0] i_cmd_byte,
    input  logic [AW-1:0]     i_cmd_addr,
    input  logic              i_cmd_last,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_frame_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [SIZE_W-1:0] o_frame_size,
    output logic              o_last
);

    logic [BYTE_W-1:0] r_mem [MAX_FRAME];

    logic              r_draining;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_size;

    logic              r_s1_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_s1_pos;
    logic [CW-1:0]     r_s1_size;
    logic              r_s1_last;

    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic [AW-1:0]     r_out_pos;
    logic [CW-1:0]     r_out_size;
    logic              r_out_last;

    logic              w_s2_load;
    logic              w_issue;
    logic              w_issue_last;

    assign o_cmd_pop    = i_cmd_valid && !r_draining;
    assign w_s2_load    = r_s1_vld && (!r_out_vld || i_ready);
    assign w_issue      = r_draining && (!r_s1_vld || w_s2_load);
    assign w_issue_last = ((CW'(r_rd_ptr) + CW'(1)) == r_size);

    assign o_valid         = r_out_vld;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_position = POS_W'(r_out_pos);
    assign o_frame_size    = SIZE_W'(r_out_size);
    assign o_last          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_mem[i_cmd_addr] <= i_cmd_byte;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_s1_pos  <= r_rd_ptr;
            r_s1_size <= r_size;
            r_s1_last <= w_issue_last;
        end
        if (w_s2_load) begin
            r_out_byte <= r_rd_data;
            r_out_pos  <= r_s1_pos;
            r_out_size <= r_s1_size;
            r_out_last <= r_s1_last;
        end
        if (o_cmd_pop && i_cmd_last) begin
            r_size <= CW'(i_cmd_addr) + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_rd_ptr   <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_cmd_pop && i_cmd_last) begin
                r_draining <= 1'b1;
                r_rd_ptr   <= '0;
            end else if (w_issue) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                if (w_issue_last) begin
                    r_draining <= 1'b0;
                end
            end
            if (w_issue) begin
                r_s1_vld <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s2_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/delimited_frame_extractor_unit.sv
// Top level of the delimited frame extractor: front end, command queue and frame buffer.
// The block takes one received byte per cycle, collects frames that open with '#' and
// close with CR LF, and sends each completed frame out one byte per item with its
// position, the frame size and tlast on the line feed. Input bytes are accepted every
// cycle while the four-entry command queue has room. A completed frame of N bytes drains
// from the single-port frame buffer at one item per cycle while the output is ready; the
// line feed passes through the command queue, then each byte goes through the read stage
// and the output register. While a frame drains the buffer takes no new bytes, so input
// stalls once the queue fills. Incomplete, malformed and oversized frames are dropped silently.
module delimited_frame_extractor_unit
    import dfe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] frame_byte, [13:8] byte_position,
                                       // [20:14] frame_size, [23:21] zero
    output logic        m_axis_tlast   // last_of_frame
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int QW = BYTE_W + AW + 1;

    logic              w_push, w_last, w_q_full, w_q_valid, w_pop;
    logic [BYTE_W-1:0] w_byte;
    logic [AW-1:0]     w_addr;
    logic [QW-1:0]     w_q_data;
    logic [BYTE_W-1:0] w_frame_byte;
    logic [POS_W-1:0]  w_pos;
    logic [SIZE_W-1:0] w_size;

    dfe_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_byte   (w_byte),
        .o_addr   (w_addr),
        .o_last   (w_last)
    );

    dfe_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_last, w_addr, w_byte}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    dfe_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_q_valid),
        .i_cmd_byte      (w_q_data[BYTE_W-1:0]),
        .i_cmd_addr      (w_q_data[BYTE_W +: AW]),
        .i_cmd_last      (w_q_data[QW-1]),
        .o_cmd_pop       (w_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_frame_byte    (w_frame_byte),
        .o_byte_position (w_pos),
        .o_frame_size    (w_size),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_size, w_pos, w_frame_byte};

endmodule

// File: rtl/dfe_checker.sv
// Port-level checker for the delimited frame extractor and its bind statement.
module dfe_checker
    import dfe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_last_matches_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tlast == (({1'b0, m_axis_tdata[13:8]} + 7'd1) == m_axis_tdata[20:14])))
        else $error("tlast does not match position and size");

    a_first_is_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[13:8] == 6'd0) |-> m_axis_tdata[7:0] == C_START)
        else $error("frame does not open with the start marker");

    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == C_LF)
        else $error("frame does not end with a line feed");

endmodule

bind delimited_frame_extractor_unit dfe_checker u_dfe_checker (.*);
